### hw/rtl/lcl_pkg.sv
// Shared types, character codes and classification helpers for the lexer.
`default_nettype none
package lcl_pkg;

   localparam logic [2:0] KIND_EMPTY    = 3'd0;
   localparam logic [2:0] KIND_INT      = 3'd1;
   localparam logic [2:0] KIND_PUNCT    = 3'd2;
   localparam logic [2:0] KIND_OTHER    = 3'd3;
   localparam logic [2:0] KIND_UNCLOSED = 3'd4;
   localparam logic [2:0] KIND_BADHEX   = 3'd5;

   localparam logic [3:0] MODE_IDLE      = 4'd0;
   localparam logic [3:0] MODE_EMPTY     = 4'd1;
   localparam logic [3:0] MODE_LINE      = 4'd2;
   localparam logic [3:0] MODE_NEST      = 4'd3;
   localparam logic [3:0] MODE_NEST_SKIP = 4'd4;
   localparam logic [3:0] MODE_HEX_SIGN  = 4'd5;
   localparam logic [3:0] MODE_HEX       = 4'd6;
   localparam logic [3:0] MODE_OCTAL     = 4'd7;
   localparam logic [3:0] MODE_OTHER     = 4'd8;
   localparam logic [3:0] MODE_SKIP      = 4'd9;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_EQUAL  = 8'h3d;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;

   // Lookahead code for "no following byte"
   localparam logic [8:0] NO_NEXT = 9'h100;

   typedef struct packed {
      logic       has_held;
      logic [7:0] held_byte;
      logic [7:0] text_byte;
      logic       end_of_text;
   } entry_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic signed [63:0] value;
      logic [15:0]       length;
   } result_type;

   typedef struct packed {
      logic       push;
      logic       seal;
      result_type data;
   } emit_type;

   typedef struct packed {
      logic [3:0] mode;
      logic       neg;
      logic       nest;
      logic       punct;
      logic       pair;
   } start_type;

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_pair(input logic [7:0] c, input logic [8:0] n);
      return (c == CH_EQUAL && n == {1'b0, CH_EQUAL}) ||
             (c == CH_LPAREN && n == {1'b0, CH_STAR}) ||
             (c == CH_STAR && n == {1'b0, CH_RPAREN});
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return c == CH_NUL || c == CH_LBRACE || c == CH_RBRACE ||
             c == CH_LBRACK || c == CH_RBRACK;
   endfunction

   function automatic logic starts_delim(input logic [7:0] c, input logic [8:0] n);
      return is_single(c) || is_space(c) || c == CH_HASH || is_pair(c, n);
   endfunction

   function automatic logic starts_empty(input logic [7:0] c, input logic [8:0] n);
      return is_space(c) || c == CH_HASH || (c == CH_LPAREN && n == {1'b0, CH_STAR});
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
         d = c - CH_0;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_LA && c <= CH_LF_HEX) begin
         d = c - CH_LA + 8'd10;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_UA && c <= CH_UF) begin
         d = c - CH_UA + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   // Classify the first byte of a new token
   function automatic start_type start_of(input logic [7:0] c, input logic [8:0] n);
      start_type r;
      r = '{mode: MODE_IDLE, neg: 1'b0, nest: 1'b0, punct: 1'b0, pair: 1'b0};
      priority if (is_space(c)) begin
         r.mode = MODE_EMPTY;
      end else if (c == CH_HASH) begin
         r.mode = MODE_LINE;
      end else if (c == CH_LPAREN && n == {1'b0, CH_STAR}) begin
         r.mode = MODE_NEST_SKIP;
         r.nest = 1'b1;
      end else if (is_single(c)) begin
         r.punct = 1'b1;
      end else if (is_pair(c, n)) begin
         r.punct = 1'b1;
         r.pair  = 1'b1;
         r.mode  = MODE_SKIP;
      end else if (c == CH_X) begin
         r.mode = MODE_HEX;
      end else if (c == CH_MINUS && n == {1'b0, CH_X}) begin
         r.mode = MODE_HEX_SIGN;
         r.neg  = 1'b1;
      end else if (c == CH_MINUS && n == {1'b0, CH_0}) begin
         r.mode = MODE_OCTAL;
         r.neg  = 1'b1;
      end else if (c == CH_0) begin
         r.mode = MODE_OCTAL;
      end else begin
         r.mode = MODE_OTHER;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lcl_if.sv
// Valid/ready channel interfaces for text bytes and tokens.
`default_nettype none
interface lcl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lcl_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         token_kind;
   logic signed [63:0] token_value;
   logic [15:0]        token_length;
   logic               last_result;
   modport source (output valid, output token_kind, output token_value,
                   output token_length, output last_result, input ready);
   modport sink (input valid, input token_kind, input token_value,
                 input token_length, input last_result, output ready);
endinterface
`default_nettype wire

### hw/rtl/lcl_front.sv
// Front end: lookahead byte register and two-entry work queue.
`default_nettype none
module lcl_front (
   input  wire logic              clock,
   input  wire logic              reset,
   lcl_req_if.sink                req,
   output lcl_pkg::entry_type     ent,
   output logic                   ent_valid,
   input  wire logic              ent_pop
);
   lcl_pkg::entry_type q_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_ff, held_in;
   logic       take, push, pop;

   assign req.ready = cnt_ff != 2'd2;
   assign take      = req.valid && req.ready;
   // a byte with nothing held and no end only fills the lookahead
   assign push      = take && (held_valid_ff || req.end_of_text);
   assign pop       = ent_pop && ent_valid;
   assign ent_valid = cnt_ff != 2'd0;
   assign ent       = q_ff[rd_ff];

   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      if (take) begin
         held_valid_in = !req.end_of_text;
         held_in       = req.text_byte;
      end
      rd_in  = pop ? !rd_ff : rd_ff;
      wr_in  = push ? !wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rd_ff         <= 1'b0;
         wr_ff         <= 1'b0;
         cnt_ff        <= 2'd0;
      end else begin
         held_valid_ff <= held_valid_in;
         rd_ff         <= rd_in;
         wr_ff         <= wr_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (push) begin
         q_ff[wr_ff] <= '{has_held: held_valid_ff, held_byte: held_ff,
                          text_byte: req.text_byte, end_of_text: req.end_of_text};
      end
   end
endmodule
`default_nettype wire

### hw/rtl/lcl_core.sv
// Back end: lexer state machine, one step per cycle unless stalled.
`default_nettype none
module lcl_core #(
   parameter int VALUE_BITS  = 64,
   parameter int LENGTH_BITS = 16,
   parameter int NEST_BITS   = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcl_pkg::entry_type ent,
   input  wire logic               ent_valid,
   output logic                    ent_pop,
   input  wire logic               out_room,
   output lcl_pkg::emit_type       emit
);
   localparam logic [1:0] PH_HELD  = 2'd0;
   localparam logic [1:0] PH_BYTE  = 2'd1;
   localparam logic [1:0] PH_FLUSH = 2'd2;

   logic [3:0]             mode_ff, mode_in;
   logic [NEST_BITS-1:0]   depth_ff, depth_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   busy_ff, busy_in;
   logic                   defer_ff, defer_in;

   logic                   go, advance, want_start;
   logic [1:0]             phase;
   logic [7:0]             c;
   logic [8:0]             n;
   lcl_pkg::start_type     st;
   logic [4:0]             hd;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [VALUE_BITS-1:0]  lit;
   logic signed [63:0]     lit_sx;
   logic [31:0]            len_wide;
   logic [LENGTH_BITS-1:0] emit_len;

   assign go    = ent_valid && out_room;
   assign phase = busy_ff ? phase_ff : (ent.has_held ? PH_HELD : PH_BYTE);
   assign c     = (phase == PH_HELD) ? ent.held_byte : ent.text_byte;
   assign n     = (phase == PH_HELD) ? {1'b0, ent.text_byte} : lcl_pkg::NO_NEXT;
   assign st    = lcl_pkg::start_of(c, n);
   assign hd    = lcl_pkg::hex_digit(c);
   assign len_inc = (&len_ff) ? len_ff : len_ff + 1'b1;
   assign lit     = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign lit_sx  = $signed(lit);
   assign len_wide = 32'(emit_len);

   always_comb begin
      mode_in    = mode_ff;
      depth_in   = depth_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      len_in     = len_ff;
      defer_in   = 1'b0;
      advance    = 1'b1;
      want_start = 1'b0;
      emit       = '0;
      emit_len   = len_ff;

      if (defer_ff) begin
         want_start = 1'b1;
      end else if (phase == PH_FLUSH) begin
         unique case (mode_ff)
            lcl_pkg::MODE_EMPTY, lcl_pkg::MODE_LINE: begin
               emit.push      = 1'b1;
               emit.data.kind = lcl_pkg::KIND_EMPTY;
            end
            lcl_pkg::MODE_NEST, lcl_pkg::MODE_NEST_SKIP: begin
               emit.push      = 1'b1;
               emit.data.kind = lcl_pkg::KIND_UNCLOSED;
            end
            lcl_pkg::MODE_HEX_SIGN, lcl_pkg::MODE_HEX, lcl_pkg::MODE_OCTAL: begin
               emit.push       = 1'b1;
               emit.data.kind  = lcl_pkg::KIND_INT;
               emit.data.value = lit_sx;
            end
            lcl_pkg::MODE_OTHER: begin
               emit.push      = 1'b1;
               emit.data.kind = lcl_pkg::KIND_OTHER;
            end
            default: begin
            end
         endcase
         mode_in  = lcl_pkg::MODE_IDLE;
         depth_in = '0;
         acc_in   = '0;
         neg_in   = 1'b0;
         len_in   = '0;
      end else begin
         unique case (mode_ff)
            lcl_pkg::MODE_SKIP: begin
               mode_in = lcl_pkg::MODE_IDLE;
            end
            lcl_pkg::MODE_EMPTY: begin
               if (lcl_pkg::starts_empty(c, n)) begin
                  len_in = len_inc;
                  if (c == lcl_pkg::CH_HASH) begin
                     mode_in = lcl_pkg::MODE_LINE;
                  end else if (c == lcl_pkg::CH_LPAREN) begin
                     depth_in = NEST_BITS'(1);
                     mode_in  = lcl_pkg::MODE_NEST_SKIP;
                  end
               end else begin
                  emit.push      = 1'b1;
                  emit.data.kind = lcl_pkg::KIND_EMPTY;
                  want_start     = 1'b1;
               end
            end
            lcl_pkg::MODE_LINE: begin
               len_in = len_inc;
               if (c == lcl_pkg::CH_LF) begin
                  mode_in = lcl_pkg::MODE_EMPTY;
               end
            end
            lcl_pkg::MODE_NEST: begin
               len_in = len_inc;
               if (c == lcl_pkg::CH_LPAREN && n == {1'b0, lcl_pkg::CH_STAR}) begin
                  if (!(&depth_ff)) depth_in = depth_ff + 1'b1;
                  mode_in = lcl_pkg::MODE_NEST_SKIP;
               end else if (c == lcl_pkg::CH_STAR && n == {1'b0, lcl_pkg::CH_RPAREN}) begin
                  if (depth_ff != '0) depth_in = depth_ff - 1'b1;
                  mode_in = lcl_pkg::MODE_NEST_SKIP;
               end
            end
            lcl_pkg::MODE_NEST_SKIP: begin
               len_in  = len_inc;
               mode_in = (depth_ff == '0) ? lcl_pkg::MODE_EMPTY : lcl_pkg::MODE_NEST;
            end
            lcl_pkg::MODE_HEX_SIGN: begin
               len_in  = len_inc;
               mode_in = lcl_pkg::MODE_HEX;
            end
            lcl_pkg::MODE_HEX: begin
               if (lcl_pkg::starts_delim(c, n)) begin
                  emit.push       = 1'b1;
                  emit.data.kind  = lcl_pkg::KIND_INT;
                  emit.data.value = lit_sx;
                  want_start      = 1'b1;
               end else if (hd[4]) begin
                  acc_in = {acc_ff[VALUE_BITS-5:0], hd[3:0]};
                  len_in = len_inc;
               end else begin
                  emit.push      = 1'b1;
                  emit.data.kind = lcl_pkg::KIND_BADHEX;
                  emit_len       = len_inc;
                  mode_in        = lcl_pkg::MODE_IDLE;
                  depth_in       = '0;
                  acc_in         = '0;
                  neg_in         = 1'b0;
                  len_in         = '0;
               end
            end
            lcl_pkg::MODE_OCTAL: begin
               if (lcl_pkg::starts_delim(c, n)) begin
                  emit.push       = 1'b1;
                  emit.data.kind  = lcl_pkg::KIND_INT;
                  emit.data.value = lit_sx;
                  want_start      = 1'b1;
               end else if (c >= lcl_pkg::CH_0 && c <= lcl_pkg::CH_7) begin
                  acc_in = {acc_ff[VALUE_BITS-4:0], c[2:0]};
                  len_in = len_inc;
               end else begin
                  len_in  = len_inc;
                  mode_in = lcl_pkg::MODE_OTHER;
               end
            end
            lcl_pkg::MODE_OTHER: begin
               if (lcl_pkg::starts_delim(c, n)) begin
                  emit.push      = 1'b1;
                  emit.data.kind = lcl_pkg::KIND_OTHER;
                  want_start     = 1'b1;
               end else begin
                  len_in = len_inc;
               end
            end
            default: begin
               want_start = 1'b1;
            end
         endcase
      end

      if (want_start) begin
         if (emit.push && st.punct) begin
            // one result per cycle: defer and retry the same byte
            defer_in = 1'b1;
            advance  = 1'b0;
         end else begin
            mode_in  = st.mode;
            depth_in = st.nest ? NEST_BITS'(1) : '0;
            acc_in   = '0;
            neg_in   = st.neg;
            len_in   = LENGTH_BITS'(1);
            if (st.punct) begin
               emit.push      = 1'b1;
               emit.data.kind = lcl_pkg::KIND_PUNCT;
               emit_len       = st.pair ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
               len_in         = '0;
            end
         end
      end

      emit.data.length = len_wide[15:0];

      phase_in = phase;
      busy_in  = busy_ff;
      ent_pop  = 1'b0;
      if (advance) begin
         unique case (phase)
            PH_HELD: begin
               if (ent.end_of_text) phase_in = PH_BYTE;
               else ent_pop = 1'b1;
            end
            PH_BYTE: phase_in = PH_FLUSH;
            default: ent_pop = 1'b1;
         endcase
      end
      busy_in   = !ent_pop;
      emit.seal = ent_pop;
      if (!go) begin
         emit = '0;
         ent_pop = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lcl_pkg::MODE_IDLE;
         depth_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         len_ff   <= '0;
         phase_ff <= PH_HELD;
         busy_ff  <= 1'b0;
         defer_ff <= 1'b0;
      end else if (go) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         len_ff   <= len_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         defer_ff <= defer_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/lcl_out_queue.sv
// Result queue; the newest result stays held until its last flag is known.
`default_nettype none
module lcl_out_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lcl_pkg::emit_type emit,
   output logic                   room,
   lcl_rsp_if.source              rsp
);
   lcl_pkg::result_type data_ff [4];
   logic [3:0] last_ff;
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff;
   logic       open_ff, open_in;
   logic       pop;

   assign room      = cnt_ff != 3'd4;
   assign rsp.valid = (cnt_ff > 3'd1) || (cnt_ff == 3'd1 && !open_ff);
   assign pop       = rsp.valid && rsp.ready;
   assign rsp.token_kind   = data_ff[rd_ff].kind;
   assign rsp.token_value  = data_ff[rd_ff].value;
   assign rsp.token_length = data_ff[rd_ff].length;
   assign rsp.last_result  = last_ff[rd_ff];

   always_comb begin
      open_in = open_ff;
      if (emit.push) open_in = 1'b1;
      if (emit.seal) open_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= 2'd0;
         wr_ff   <= 2'd0;
         cnt_ff  <= 3'd0;
         open_ff <= 1'b0;
      end else begin
         rd_ff   <= rd_ff + {1'b0, pop};
         wr_ff   <= wr_ff + {1'b0, emit.push};
         cnt_ff  <= cnt_ff + {2'b0, emit.push} - {2'b0, pop};
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      // mark the newest result of the finished item as its last
      if (emit.push) begin
         data_ff[wr_ff] <= emit.data;
         last_ff[wr_ff] <= emit.seal;
      end else if (emit.seal && open_ff) begin
         last_ff[wr_ff - 2'd1] <= 1'b1;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/literal_and_comment_lexer.sv
// Streaming lexer top level: front end, lexer core and result queue.
// One text byte is taken per transfer and held back as lookahead for the next. The lexer
// core lexes each byte in a step of its own, with an extra deferred step when a token ends
// right at a brace, bracket, NUL, "==" or "*)" (two results from one step); a byte marked
// end_of_text is lexed itself and then the pending token is flushed. Up to three tokens
// follow one byte, the last flagged by last_result. The core gives at most one result per
// cycle, hence the deferred step.
`default_nettype none
module literal_and_comment_lexer #(
   parameter int VALUE_BITS  = 64,
   parameter int LENGTH_BITS = 16,
   parameter int NEST_BITS   = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   lcl_req_if.sink   req_chan,
   lcl_rsp_if.source rsp_chan
);
   lcl_pkg::entry_type ent;
   lcl_pkg::emit_type  emit;
   logic               ent_valid, ent_pop, room;

   lcl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .ent       (ent),
      .ent_valid (ent_valid),
      .ent_pop   (ent_pop)
   );

   lcl_core #(
      .VALUE_BITS  (VALUE_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .NEST_BITS   (NEST_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ent       (ent),
      .ent_valid (ent_valid),
      .ent_pop   (ent_pop),
      .out_room  (room),
      .emit      (emit)
   );

   lcl_out_queue u_out (
      .clock (clock),
      .reset (reset),
      .emit  (emit),
      .room  (room),
      .rsp   (rsp_chan)
   );
endmodule
`default_nettype wire
